// ===== hdl/pending_transaction_table_defines.svh =====
// assertion helpers for the pending transaction table rtl
`ifndef PENDING_TRANSACTION_TABLE_DEFINES_SVH
`define PENDING_TRANSACTION_TABLE_DEFINES_SVH

// same-cycle implication, disabled during reset
`define PTT_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pending table check failed");

// next-cycle implication, disabled during reset
`define PTT_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pending table check failed");

`endif

// ===== hdl/ptt_pkg.sv =====
// ---------------------------------------------------------------------------
// ptt_pkg
// shared codes and controller/datapath signal groups for the pending table
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ptt_pkg;

  // operation codes
  localparam logic [1:0] OP_NEW    = 2'd0;
  localparam logic [1:0] OP_FIND   = 2'd1;
  localparam logic [1:0] OP_REMOVE = 2'd2;
  localparam logic [1:0] OP_EXPIRE = 2'd3;

  // result status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [1:0] ST_RANGE     = 2'd3;

  localparam logic [30:0] MAX_AGE_RESET = 31'd60;
  localparam logic [31:0] FIRST_ID      = 32'd1;

  // controller to datapath commands
  typedef struct packed {
    logic take;
    logic clear;
    logic new_rd;
    logic new_wr;
    logic find;
    logic rem_rd;
    logic rem_wr;
    logic expire;
    logic load;
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic       in_valid;
    logic [1:0] in_op;
    logic       full;
    logic       slot_bad;
    logic       clear_last;
    logic       find_done;
    logic       exp_done;
    logic       out_free;
  } sts_t;

endpackage

`default_nettype wire

// ===== hdl/ptt_if.sv =====
// ---------------------------------------------------------------------------
// ptt request and response channels
// valid/ready channels carrying one transaction each
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface ptt_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [31:0] now_secs;
  logic [3:0]  txn_type;
  logic [63:0] target_word;
  logic        target_given;
  logic [31:0] lookup_id;
  logic [4:0]  slot_index;

  modport source (output valid, opcode, now_secs, txn_type, target_word, target_given,
                  lookup_id, slot_index, input ready);
  modport sink (input valid, opcode, now_secs, txn_type, target_word, target_given,
                lookup_id, slot_index, output ready);
endinterface

interface ptt_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [31:0] result_id;
  logic [4:0]  result_slot;
  logic [3:0]  result_type;
  logic [63:0] result_target;
  logic [31:0] result_created;
  logic [5:0]  expired_count;
  logic [5:0]  entries_held;

  modport source (output valid, status, result_id, result_slot, result_type, result_target,
                  result_created, expired_count, entries_held, input ready);
  modport sink (input valid, status, result_id, result_slot, result_type, result_target,
                result_created, expired_count, entries_held, output ready);
endinterface

`default_nettype wire

// ===== hdl/ptt_ctrl.sv =====
// ---------------------------------------------------------------------------
// ptt_ctrl
// operation sequencer for the pending transaction table
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ptt_ctrl
  import ptt_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  sts_t sts,
  output cmd_t cmd
);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_NEW_RD, S_NEW_WR, S_FIND, S_REM_RD, S_REM_WR, S_EXPIRE, S_RESULT
  } state_t;

  state_t state;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      unique case (state)
        S_CLEAR: begin
          if (sts.clear_last) state <= S_IDLE;
        end
        S_IDLE: begin
          if (sts.in_valid) begin
            unique case (sts.in_op)
              OP_NEW:    state <= sts.full ? S_RESULT : S_NEW_RD;
              OP_FIND:   state <= S_FIND;
              OP_REMOVE: state <= sts.slot_bad ? S_RESULT : S_REM_RD;
              OP_EXPIRE: state <= S_EXPIRE;
              default:   state <= S_IDLE;
            endcase
          end
        end
        S_NEW_RD: state <= S_NEW_WR;
        S_NEW_WR: state <= S_RESULT;
        S_REM_RD: state <= S_REM_WR;
        S_REM_WR: state <= S_RESULT;
        S_FIND: begin
          if (sts.find_done) state <= S_RESULT;
        end
        S_EXPIRE: begin
          if (sts.exp_done) state <= S_RESULT;
        end
        S_RESULT: begin
          if (sts.out_free) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // command decode
  always_comb begin
    cmd        = '0;
    cmd.take   = (state == S_IDLE);
    cmd.clear  = (state == S_CLEAR);
    cmd.new_rd = (state == S_NEW_RD);
    cmd.new_wr = (state == S_NEW_WR);
    cmd.find   = (state == S_FIND);
    cmd.rem_rd = (state == S_REM_RD);
    cmd.rem_wr = (state == S_REM_WR);
    cmd.expire = (state == S_EXPIRE);
    cmd.load   = (state == S_RESULT) && sts.out_free;
  end

endmodule

`default_nettype wire

// ===== hdl/ptt_datapath.sv =====
// ---------------------------------------------------------------------------
// ptt_datapath
// entry memory, counters, walk pointers and result register
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "pending_transaction_table_defines.svh"

module ptt_datapath
  import ptt_pkg::*;
#(
  parameter int DEPTH       = 32,
  parameter int TARGET_BITS = 64
) (
  input  logic        clk,
  input  logic        rst,
  ptt_req_if.sink     req,
  ptt_rsp_if.source   rsp,
  input  logic        cfg_we,
  input  logic [30:0] cfg_data,
  input  cmd_t        cmd,
  output sts_t        sts
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = (CW > 5) ? CW : 5;

  // entry memory, one row per slot
  logic [31:0]            id_mem      [DEPTH];
  logic [3:0]             type_mem    [DEPTH];
  logic [31:0]            created_mem [DEPTH];
  logic [TARGET_BITS-1:0] target_mem  [DEPTH];

  logic [31:0]            rd_id;
  logic [3:0]             rd_type;
  logic [31:0]            rd_created;
  logic [TARGET_BITS-1:0] rd_target;

  // captured transaction
  logic [31:0]            req_now;
  logic [3:0]             req_type;
  logic [TARGET_BITS-1:0] req_target;
  logic                   req_given;
  logic [31:0]            req_lookup;
  logic [4:0]             req_slot;

  // table state and walk
  logic [CW-1:0] count;
  logic [31:0]   next_id;
  logic [30:0]   max_age;
  logic [CW-1:0] idx;
  logic          pend;
  logic [AW-1:0] pend_idx;
  logic [CW-1:0] wr_ptr;
  logic [CW-1:0] dropped;

  // staged result
  logic [1:0]             res_status;
  logic [31:0]            res_id;
  logic [4:0]             res_slot;
  logic [3:0]             res_type;
  logic [TARGET_BITS-1:0] res_target;
  logic [31:0]            res_created;
  logic [5:0]             res_expired;

  logic [CW-1:0]          last;
  logic [AW-1:0]          rd_addr;
  logic                   hit;
  logic                   more;
  logic [31:0]            age;
  logic                   drop;
  logic                   we;
  logic [AW-1:0]          wa;
  logic [31:0]            w_id;
  logic [3:0]             w_type;
  logic [31:0]            w_created;
  logic [TARGET_BITS-1:0] w_target;
  logic [31:0]            id_next;
  logic                   in_take;

  // walk and compare logic
  always_comb begin
    last    = count - CW'(1);
    in_take = cmd.take && req.valid;
    hit     = pend && (rd_id == req_lookup);
    more    = idx < count;
    age     = req_now - rd_created;
    drop    = age > {1'b0, max_age};
    id_next = (next_id == '1) ? FIRST_ID : next_id + 32'd1;
    priority if (cmd.new_rd) begin
      rd_addr = count[AW-1:0];
    end else if (cmd.rem_rd) begin
      rd_addr = last[AW-1:0];
    end else begin
      rd_addr = idx[AW-1:0];
    end
  end

  // memory write select
  always_comb begin
    we        = 1'b0;
    wa        = idx[AW-1:0];
    w_id      = rd_id;
    w_type    = rd_type;
    w_created = rd_created;
    w_target  = rd_target;
    priority if (cmd.clear) begin
      we        = 1'b1;
      w_id      = '0;
      w_type    = '0;
      w_created = '0;
      w_target  = '0;
    end else if (cmd.new_wr) begin
      we        = 1'b1;
      wa        = count[AW-1:0];
      w_id      = next_id;
      w_type    = req_type;
      w_created = req_now;
      w_target  = req_given ? req_target : rd_target;
    end else if (cmd.rem_wr) begin
      we = 1'b1;
      wa = AW'(req_slot);
    end else if (cmd.expire && pend && !drop) begin
      we = 1'b1;
      wa = wr_ptr[AW-1:0];
    end
  end

  // memory ports
  always_ff @(posedge clk) begin
    if (we) begin
      id_mem[wa]      <= w_id;
      type_mem[wa]    <= w_type;
      created_mem[wa] <= w_created;
      target_mem[wa]  <= w_target;
    end
    rd_id      <= id_mem[rd_addr];
    rd_type    <= type_mem[rd_addr];
    rd_created <= created_mem[rd_addr];
    rd_target  <= target_mem[rd_addr];
  end

  // status to controller
  always_comb begin
    sts.in_valid   = req.valid;
    sts.in_op      = req.opcode;
    sts.full       = (count == CW'(DEPTH));
    sts.slot_bad   = SW'(req.slot_index) >= SW'(count);
    sts.clear_last = (idx == CW'(DEPTH - 1));
    sts.find_done  = hit || !more;
    sts.exp_done   = !pend && !more;
    sts.out_free   = !rsp.valid || rsp.ready;
  end

  assign req.ready = cmd.take;

  // table state, walk and result
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      next_id   <= FIRST_ID;
      max_age   <= MAX_AGE_RESET;
      idx       <= '0;
      pend      <= 1'b0;
      rsp.valid <= 1'b0;
    end else begin
      if (cfg_we) max_age <= cfg_data;
      if (cmd.clear) idx <= idx + CW'(1);

      // capture a new transaction
      if (in_take) begin
        req_now     <= req.now_secs;
        req_type    <= req.txn_type;
        req_target  <= req.target_word[TARGET_BITS-1:0];
        req_given   <= req.target_given;
        req_lookup  <= req.lookup_id;
        req_slot    <= req.slot_index;
        idx         <= '0;
        pend        <= 1'b0;
        wr_ptr      <= '0;
        dropped     <= '0;
        res_id      <= '0;
        res_slot    <= '0;
        res_type    <= '0;
        res_target  <= '0;
        res_created <= '0;
        res_expired <= '0;
        if (req.opcode == OP_NEW && sts.full) begin
          res_status <= ST_FULL;
        end else if (req.opcode == OP_REMOVE && sts.slot_bad) begin
          res_status <= ST_RANGE;
        end else begin
          res_status <= ST_OK;
        end
      end

      // append
      if (cmd.new_wr) begin
        count       <= count + CW'(1);
        next_id     <= id_next;
        res_id      <= next_id;
        res_slot    <= 5'(count);
        res_type    <= req_type;
        res_target  <= w_target;
        res_created <= req_now;
      end

      // remove by moving the last entry down
      if (cmd.rem_wr) count <= last;

      // find walk
      if (cmd.find) begin
        if (hit) begin
          pend        <= 1'b0;
          res_id      <= rd_id;
          res_slot    <= 5'(pend_idx);
          res_type    <= rd_type;
          res_target  <= rd_target;
          res_created <= rd_created;
        end else if (more) begin
          pend     <= 1'b1;
          pend_idx <= idx[AW-1:0];
          idx      <= idx + CW'(1);
        end else begin
          pend       <= 1'b0;
          res_status <= ST_NOT_FOUND;
        end
      end

      // expire walk with in-order compaction
      if (cmd.expire) begin
        if (pend && drop) dropped <= dropped + CW'(1);
        if (pend && !drop) wr_ptr <= wr_ptr + CW'(1);
        if (more) begin
          pend     <= 1'b1;
          pend_idx <= idx[AW-1:0];
          idx      <= idx + CW'(1);
        end else begin
          pend <= 1'b0;
        end
        if (sts.exp_done) begin
          count       <= wr_ptr;
          res_expired <= 6'(dropped);
        end
      end

      // output register
      if (cmd.load) begin
        rsp.valid          <= 1'b1;
        rsp.status         <= res_status;
        rsp.result_id      <= res_id;
        rsp.result_slot    <= res_slot;
        rsp.result_type    <= res_type;
        rsp.result_target  <= 64'(res_target);
        rsp.result_created <= res_created;
        rsp.expired_count  <= res_expired;
        rsp.entries_held   <= 6'(count);
      end else if (rsp.valid && rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

  `PTT_ASSERT_NOW(a_count_bound, clk, rst, 1'b1, count <= CW'(DEPTH))
  `PTT_ASSERT_NOW(a_id_nonzero, clk, rst, 1'b1, next_id != 32'd0)
  `PTT_ASSERT_NOW(a_compact_behind, clk, rst, cmd.expire && pend, wr_ptr <= CW'(pend_idx))
  `PTT_ASSERT_NEXT(a_rsp_from_load, clk, rst, !rsp.valid && !cmd.load, !rsp.valid)

endmodule

`default_nettype wire

// ===== hdl/pending_transaction_table.sv =====
// ---------------------------------------------------------------------------
// pending_transaction_table
// table of pending transactions with allocate, find, remove and expire
// ---------------------------------------------------------------------------
// One transaction at a time. After reset the table runs a clearing pass over
// its entry memory and takes no request meanwhile (max_age writes are taken).
// New and remove read and then write the entry memory; a full table or an
// out-of-range slot goes straight to the result. Find and expire walk the
// entries through the single read port of the entry memory, one slot per
// cycle. A response may wait in its register while the next request is
// accepted.
`timescale 1ns / 1ps
`default_nettype none

module pending_transaction_table
  import ptt_pkg::*;
#(
  parameter int DEPTH       = 32,
  parameter int TARGET_BITS = 64
) (
  input  logic        clk,
  input  logic        rst,
  ptt_req_if.sink     req,
  ptt_rsp_if.source   rsp,
  input  logic        cfg_we,
  input  logic [30:0] cfg_data
);

  cmd_t cmd;
  sts_t sts;

  // sequencer
  ptt_ctrl u_ctrl (
    .clk (clk),
    .rst (rst),
    .sts (sts),
    .cmd (cmd)
  );

  // storage and arithmetic
  ptt_datapath #(
    .DEPTH       (DEPTH),
    .TARGET_BITS (TARGET_BITS)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .req      (req),
    .rsp      (rsp),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .cmd      (cmd),
    .sts      (sts)
  );

endmodule

`default_nettype wire

// ===== sim/pending_transaction_table_tb.sv =====
// ---------------------------------------------------------------------------
// pending_transaction_table_tb
// self-checking bench: a table model predicts each response, directed tests
// cover the table limits and special cases, then random traffic runs
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pending_transaction_table_tb;
  import ptt_pkg::*;

  localparam int DEPTH = 32;
  localparam int CYCLE_LIMIT = 2000000;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [31:0] now_secs;
    logic [3:0]  txn_type;
    logic [63:0] target_word;
    logic        target_given;
    logic [31:0] lookup_id;
    logic [4:0]  slot_index;
  } txn_req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] result_id;
    logic [4:0]  result_slot;
    logic [3:0]  result_type;
    logic [63:0] result_target;
    logic [31:0] result_created;
    logic [5:0]  expired_count;
    logic [5:0]  entries_held;
  } txn_rsp_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [30:0] cfg_data = '0;

  ptt_req_if req ();
  ptt_rsp_if rsp ();

  pending_transaction_table dut (
    .clk(clk), .rst(rst), .req(req), .rsp(rsp), .cfg_we(cfg_we), .cfg_data(cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // table model state
  logic [31:0] tbl_id [DEPTH];
  logic [3:0]  tbl_type [DEPTH];
  logic [31:0] tbl_created [DEPTH];
  logic [63:0] tbl_target [DEPTH];
  int          tbl_count;
  logic [31:0] tbl_next_id;
  logic [30:0] tbl_max_age;

  txn_rsp_t pending_rsp [$];
  int  failures = 0;
  int  cycles = 0;
  bit  hold_off = 1'b0;
  bit  burst_mode = 1'b1;
  logic [31:0] clock_now = 32'd1000;

  function automatic txn_rsp_t slot_report(int s);
    txn_rsp_t r;
    r = '0;
    r.result_id = tbl_id[s];
    r.result_slot = s[4:0];
    r.result_type = tbl_type[s];
    r.result_target = tbl_target[s];
    r.result_created = tbl_created[s];
    return r;
  endfunction

  // apply one transaction to the table model and return its response
  function automatic txn_rsp_t table_apply(txn_req_t t);
    txn_rsp_t r;
    int w;
    int dropped;
    logic [31:0] age;
    r = '0;
    case (t.opcode)
      OP_NEW: begin
        if (tbl_count >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          tbl_id[tbl_count] = tbl_next_id;
          tbl_next_id = tbl_next_id + 32'd1;
          if (tbl_next_id == 32'd0) tbl_next_id = 32'd1;
          tbl_type[tbl_count] = t.txn_type;
          tbl_created[tbl_count] = t.now_secs;
          if (t.target_given) tbl_target[tbl_count] = t.target_word;
          r = slot_report(tbl_count);
          tbl_count++;
        end
      end
      OP_FIND: begin
        r.status = ST_NOT_FOUND;
        for (int i = 0; i < tbl_count; i++) begin
          if (tbl_id[i] == t.lookup_id) begin
            r = slot_report(i);
            break;
          end
        end
      end
      OP_REMOVE: begin
        if (int'(t.slot_index) >= tbl_count) begin
          r.status = ST_RANGE;
        end else begin
          tbl_id[t.slot_index] = tbl_id[tbl_count-1];
          tbl_type[t.slot_index] = tbl_type[tbl_count-1];
          tbl_created[t.slot_index] = tbl_created[tbl_count-1];
          tbl_target[t.slot_index] = tbl_target[tbl_count-1];
          tbl_count--;
        end
      end
      default: begin
        w = 0;
        dropped = 0;
        for (int i = 0; i < tbl_count; i++) begin
          age = t.now_secs - tbl_created[i];
          if (age > {1'b0, tbl_max_age}) begin
            dropped++;
          end else begin
            tbl_id[w] = tbl_id[i];
            tbl_type[w] = tbl_type[i];
            tbl_created[w] = tbl_created[i];
            tbl_target[w] = tbl_target[i];
            w++;
          end
        end
        tbl_count = w;
        r.expired_count = dropped[5:0];
      end
    endcase
    r.entries_held = tbl_count[5:0];
    return r;
  endfunction

  // send one transaction and record its expected response
  task automatic send_txn(txn_req_t t);
    int gap;
    if (burst_mode && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 6);
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req.valid <= 1'b1;
    req.opcode <= t.opcode;
    req.now_secs <= t.now_secs;
    req.txn_type <= t.txn_type;
    req.target_word <= t.target_word;
    req.target_given <= t.target_given;
    req.lookup_id <= t.lookup_id;
    req.slot_index <= t.slot_index;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    pending_rsp.push_back(table_apply(t));
  endtask

  function automatic txn_req_t rand_fields();
    txn_req_t t;
    t.opcode = 2'($urandom_range(0, 3));
    t.now_secs = $urandom();
    t.txn_type = 4'($urandom_range(0, 15));
    t.target_word = {$urandom(), $urandom()};
    t.target_given = 1'($urandom_range(0, 1));
    t.lookup_id = $urandom();
    t.slot_index = 5'($urandom_range(0, 31));
    return t;
  endfunction

  function automatic txn_req_t make_new(logic [31:0] now_v);
    txn_req_t t;
    t = rand_fields();
    t.opcode = OP_NEW;
    t.now_secs = now_v;
    return t;
  endfunction

  // stop offering, wait for every response, then let the block settle
  task automatic drain_idle();
    req.valid <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (DEPTH + 8) @(posedge clk);
  endtask

  task automatic write_max_age(logic [30:0] v);
    drain_idle();
    cfg_we <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    tbl_max_age = v;
  endtask

  // response checker
  always @(posedge clk) begin
    txn_rsp_t got;
    txn_rsp_t want;
    cycles <= cycles + 1;
    if (!rst && rsp.valid && rsp.ready) begin
      got = {rsp.status, rsp.result_id, rsp.result_slot, rsp.result_type,
             rsp.result_target, rsp.result_created, rsp.expired_count, rsp.entries_held};
      if (pending_rsp.size() == 0) begin
        $error("unexpected response %p", got);
        failures++;
      end else begin
        want = pending_rsp.pop_front();
        if (got.status !== want.status) begin
          $error("status exp %0d got %0d", want.status, got.status); failures++;
        end
        if (got.result_id !== want.result_id) begin
          $error("result_id exp %h got %h", want.result_id, got.result_id); failures++;
        end
        if (got.result_slot !== want.result_slot) begin
          $error("result_slot exp %0d got %0d", want.result_slot, got.result_slot);
          failures++;
        end
        if (got.result_type !== want.result_type) begin
          $error("result_type exp %0d got %0d", want.result_type, got.result_type);
          failures++;
        end
        if (got.result_target !== want.result_target) begin
          $error("result_target exp %h got %h", want.result_target, got.result_target);
          failures++;
        end
        if (got.result_created !== want.result_created) begin
          $error("result_created exp %h got %h", want.result_created, got.result_created);
          failures++;
        end
        if (got.expired_count !== want.expired_count) begin
          $error("expired_count exp %0d got %0d", want.expired_count, got.expired_count);
          failures++;
        end
        if (got.entries_held !== want.entries_held) begin
          $error("entries_held exp %0d got %0d", want.entries_held, got.entries_held);
          failures++;
        end
      end
    end
  end

  // receiver stall pattern, with a long hold-off on request
  always @(posedge clk) begin
    if (rst || hold_off) rsp.ready <= 1'b0;
    else if (cycles % 1000 < 300) rsp.ready <= 1'b1;
    else rsp.ready <= ($urandom_range(0, 3) != 0);
  end

  always @(posedge clk) begin
    if (cycles >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // fill past depth, full status, find hits and misses, removes in and out of range
  task automatic test_limits();
    txn_req_t t;
    for (int i = 0; i < DEPTH + 1; i++) begin
      t = make_new(32'd100 + i);
      if (i == 0) begin
        t.target_word = '1; t.target_given = 1'b1; t.txn_type = 4'hF;
      end
      if (i == 1) begin
        t.target_word = '0; t.target_given = 1'b1; t.txn_type = 4'h0;
      end
      send_txn(t);
    end
    t = rand_fields(); t.opcode = OP_FIND; t.lookup_id = 32'd5; send_txn(t);
    t.lookup_id = 32'd0; send_txn(t);
    t.lookup_id = 32'hFFFF_FFFF; send_txn(t);
    t = rand_fields(); t.opcode = OP_REMOVE; t.slot_index = 5'd31; send_txn(t);
    t.slot_index = 5'd0; send_txn(t);
    t.slot_index = 5'd31; send_txn(t);
  endtask

  // expire with age at, just past and wrapping around the limit
  task automatic test_expire();
    txn_req_t t;
    t = rand_fields(); t.opcode = OP_EXPIRE; t.now_secs = 32'd100 + 60; send_txn(t);
    t.now_secs = 32'd100 + 75; send_txn(t);
    t.now_secs = 32'd50; send_txn(t);
    t.now_secs = 32'hFFFF_FF00; send_txn(t);
    t = rand_fields(); t.opcode = OP_REMOVE; t.slot_index = 5'd0; send_txn(t);
    // stale slot target inherited
    t = make_new(32'd10); t.target_given = 1'b0; send_txn(t);
    t = make_new(32'd11); t.target_given = 1'b0; send_txn(t);
  endtask

  // random traffic, finds and removes mostly of live entries
  task automatic test_random(int n);
    txn_req_t t;
    int pick;
    for (int i = 0; i < n; i++) begin
      t = rand_fields();
      pick = $urandom_range(0, 99);
      clock_now = clock_now + $urandom_range(0, 8);
      t.now_secs = ($urandom_range(0, 19) == 0) ? $urandom() : clock_now;
      if (pick < 40) t.opcode = OP_NEW;
      else if (pick < 60) begin
        t.opcode = OP_FIND;
        if (tbl_count > 0 && $urandom_range(0, 3) != 0)
          t.lookup_id = tbl_id[$urandom_range(0, tbl_count - 1)];
        else if ($urandom_range(0, 1)) t.lookup_id = tbl_next_id - $urandom_range(0, 40);
      end else if (pick < 85) begin
        t.opcode = OP_REMOVE;
        if (tbl_count > 0 && $urandom_range(0, 4) != 0)
          t.slot_index = 5'($urandom_range(0, tbl_count - 1));
      end else begin
        t.opcode = OP_EXPIRE;
        if ($urandom_range(0, 2) != 0) t.now_secs = clock_now;
      end
      send_txn(t);
    end
  endtask

  // receiver holds off while the sender keeps offering
  task automatic test_backpressure();
    fork
      begin
        hold_off = 1'b1;
        repeat (400) @(posedge clk);
        hold_off = 1'b0;
      end
      test_random(20);
    join
  endtask

  initial begin
    req.valid = 1'b0;
    req.opcode = OP_NEW;
    req.now_secs = '0;
    req.txn_type = '0;
    req.target_word = '0;
    req.target_given = 1'b0;
    req.lookup_id = '0;
    req.slot_index = '0;
    tbl_count = 0;
    tbl_next_id = FIRST_ID;
    tbl_max_age = MAX_AGE_RESET;
    for (int i = 0; i < DEPTH; i++) tbl_target[i] = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    repeat (DEPTH + 4) @(posedge clk);

    test_limits();
    test_expire();
    write_max_age(31'd0);
    test_random(250);
    test_backpressure();
    write_max_age(31'h7FFF_FFFF);
    test_random(250);
    write_max_age(31'd40);
    burst_mode = 1'b0;
    test_random(150);
    burst_mode = 1'b1;
    write_max_age(31'($urandom_range(10, 200)));
    test_random(420);

    drain_idle();
    if (failures == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== sim.f =====
+incdir+hdl
hdl/ptt_pkg.sv
hdl/ptt_if.sv
hdl/ptt_ctrl.sv
hdl/ptt_datapath.sv
hdl/pending_transaction_table.sv
sim/pending_transaction_table_tb.sv
